### design/ntt_r2_pkg.sv
// Shared types, constants and helper functions for the radix-2 NTT block.
// Used by ntt_r2_mulmod, ntt_r2_engine and ntt_radix2_transform.
// No dependencies.
`default_nettype none
package ntt_r2_pkg;

  localparam int DATA_W   = 31;
  localparam int ADDR_W   = 6;
  localparam int CNT_W    = 7;
  localparam int LOG_W    = 3;
  localparam int MAX_LOG  = 6;
  localparam int BIT_W    = 5;

  localparam logic [1:0] REG_MODULUS = 2'd0;
  localparam logic [1:0] REG_ROOT    = 2'd1;
  localparam logic [1:0] REG_LOG_LEN = 2'd2;

  localparam logic [DATA_W-1:0] MODULUS_RST = 31'd7681;
  localparam logic [DATA_W-1:0] ROOT_RST    = 31'd17;
  localparam logic [LOG_W-1:0]  LOG_LEN_RST = 3'd6;

  typedef struct packed {
    logic [DATA_W-1:0] q;
    logic [DATA_W-1:0] root;
    logic [LOG_W-1:0]  lg;
  } ntt_cfg_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } mm_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] res;
  } mm_rsp_t;

  function automatic logic [ADDR_W-1:0] bit_rev(input logic [ADDR_W-1:0] idx,
                                                input logic [LOG_W-1:0]  lg);
    logic [ADDR_W-1:0] r;
    r = '0;
    for (int k = 0; k < ADDR_W; k++) begin
      if (LOG_W'(k) < lg) begin
        r[LOG_W'(lg - LOG_W'(k) - 3'd1)] = idx[k];
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### design/ntt_radix2_transform.sv
// Top level of the radix-2 number theoretic transform block.
// Holds the configuration registers; uses ntt_r2_pkg and ntt_r2_engine.
//
// Coefficients are written in index order, one per transfer, each reduced
// modulo q by a bit-serial multiplier before the next is accepted. When
// n = 2^log_length coefficients are in, the block permutes them, runs log2(n)
// butterfly stages in place in a 64-entry memory, and sends all n results in
// index order, each read from memory and held until it is taken. Each stage
// first derives its twiddle by square-and-multiply and then works through its
// butterflies one after another, as every modular product goes through the
// one shared multiplier; an inverse transform adds one more exponentiation
// and a scaling pass over all coefficients. If the modulus was changed while
// a vector was being loaded, a reduction pass over all coefficients runs
// before the permutation. No new coefficient is accepted until the last
// result of the previous vector has been transferred.
`default_nettype none
module ntt_radix2_transform
  import ntt_r2_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [DATA_W-1:0] cfg_data,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [31:0]       in_tdata,  // [30:0] coefficient, [31] zero
  input  wire logic              in_tuser,  // [0] inverse
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [31:0]            out_tdata, // [30:0] value, [31] zero
  output logic                   out_tlast
);

  logic [DATA_W-1:0] modulus_r, modulus_nxt;
  logic [DATA_W-1:0] root_r, root_nxt;
  logic [LOG_W-1:0]  log_len_r, log_len_nxt;
  ntt_cfg_t          cfg;
  logic [DATA_W-1:0] out_value;

  always_comb begin
    modulus_nxt = modulus_r;
    root_nxt    = root_r;
    log_len_nxt = log_len_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MODULUS: modulus_nxt = cfg_data;
        REG_ROOT:    root_nxt    = cfg_data;
        REG_LOG_LEN: log_len_nxt = cfg_data[LOG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MODULUS_RST;
      root_r    <= ROOT_RST;
      log_len_r <= LOG_LEN_RST;
    end else begin
      modulus_r <= modulus_nxt;
      root_r    <= root_nxt;
      log_len_r <= log_len_nxt;
    end
  end

  always_comb begin
    cfg.q    = (modulus_r < DATA_W'(3)) ? DATA_W'(3) : modulus_r;
    cfg.root = root_r;
    if (log_len_r == '0) begin
      cfg.lg = LOG_W'(1);
    end else if (log_len_r > LOG_W'(MAX_LOG)) begin
      cfg.lg = LOG_W'(MAX_LOG);
    end else begin
      cfg.lg = log_len_r;
    end
  end

  ntt_r2_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_coef  (in_tdata[DATA_W-1:0]),
    .in_inv   (in_tuser),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_value(out_value),
    .out_last (out_tlast)
  );

  assign out_tdata = {1'b0, out_value};

endmodule
`default_nettype wire

### design/ntt_r2_mulmod.sv
// Bit-serial modular multiplier: computes a * b mod q, one bit of b per cycle.
// Requires a below q; b may take any value. Uses ntt_r2_pkg.
`default_nettype none
module ntt_r2_mulmod
  import ntt_r2_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [DATA_W-1:0] q,
  input  wire mm_req_t           req,
  output mm_rsp_t                rsp
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [BIT_W-1:0]  k_r, k_nxt;
  logic [DATA_W-1:0] a_r, a_nxt;
  logic [DATA_W-1:0] b_r, b_nxt;
  logic [DATA_W-1:0] q_r, q_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [DATA_W+2:0] t, t1, t2, q1, q2;

  always_comb begin
    q1 = (DATA_W+3)'(q_r);
    q2 = q1 << 1;
    t  = ((DATA_W+3)'(acc_r) << 1) + (b_r[DATA_W-1] ? (DATA_W+3)'(a_r) : '0);
    t1 = t - q1;
    t2 = t - q2;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    k_nxt    = k_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    q_nxt    = q_r;
    acc_nxt  = acc_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      k_nxt    = BIT_W'(DATA_W - 1);
      a_nxt    = req.a;
      b_nxt    = req.b;
      q_nxt    = q;
      acc_nxt  = '0;
    end else if (busy_r) begin
      if (t >= q2) begin
        acc_nxt = DATA_W'(t2);
      end else if (t >= q1) begin
        acc_nxt = DATA_W'(t1);
      end else begin
        acc_nxt = DATA_W'(t);
      end
      b_nxt = b_r << 1;
      if (k_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        k_nxt = k_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    k_r   <= k_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    q_r   <= q_nxt;
    acc_r <= acc_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = acc_r;

endmodule
`default_nettype wire

### design/ntt_r2_engine.sv
// Coefficient memory and sequencer: load, bit-reversal, butterfly stages,
// twiddle exponentiation, inverse scaling and read-out. Uses ntt_r2_pkg
// and ntt_r2_mulmod.
`default_nettype none
module ntt_r2_engine
  import ntt_r2_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ntt_cfg_t          cfg,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [DATA_W-1:0] in_coef,
  input  wire logic              in_inv,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [DATA_W-1:0]      out_value,
  output logic                   out_last
);

  localparam logic [4:0] S_LOAD   = 5'd0;
  localparam logic [4:0] S_LRED   = 5'd1;
  localparam logic [4:0] S_PERM   = 5'd2;
  localparam logic [4:0] S_P1     = 5'd3;
  localparam logic [4:0] S_P2     = 5'd4;
  localparam logic [4:0] S_P3     = 5'd5;
  localparam logic [4:0] S_TW     = 5'd6;
  localparam logic [4:0] S_TW_W   = 5'd7;
  localparam logic [4:0] S_PW_SQ  = 5'd8;
  localparam logic [4:0] S_PW_SQW = 5'd9;
  localparam logic [4:0] S_PW_ML  = 5'd10;
  localparam logic [4:0] S_PW_MLW = 5'd11;
  localparam logic [4:0] S_PW_NX  = 5'd12;
  localparam logic [4:0] S_BF_INI = 5'd13;
  localparam logic [4:0] S_BF_RA  = 5'd14;
  localparam logic [4:0] S_BF_RB  = 5'd15;
  localparam logic [4:0] S_BF_U   = 5'd16;
  localparam logic [4:0] S_BF_MW  = 5'd17;
  localparam logic [4:0] S_BF_WB  = 5'd18;
  localparam logic [4:0] S_BF_WW  = 5'd19;
  localparam logic [4:0] S_NV     = 5'd20;
  localparam logic [4:0] S_NV_W   = 5'd21;
  localparam logic [4:0] S_SC_RD  = 5'd22;
  localparam logic [4:0] S_SC_M   = 5'd23;
  localparam logic [4:0] S_SC_W   = 5'd24;
  localparam logic [4:0] S_OUT_RD = 5'd25;
  localparam logic [4:0] S_OUT_LD = 5'd26;
  localparam logic [4:0] S_OUT_W  = 5'd27;

  localparam logic [DATA_W-1:0] ONE = DATA_W'(1);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_r;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              wr_en;

  mm_req_t mm_req;
  mm_rsp_t mm_rsp;

  logic [4:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              dir_r, dir_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [DATA_W-1:0] tmp_r, tmp_nxt;
  logic [LOG_W-1:0]  s_r, s_nxt;
  logic [CNT_W-1:0]  st_r, st_nxt;
  logic [ADDR_W-1:0] j_r, j_nxt;
  logic [DATA_W-1:0] w_r, w_nxt;
  logic [DATA_W-1:0] wl_r, wl_nxt;
  logic [DATA_W-1:0] u_r, u_nxt;
  logic [DATA_W-1:0] diff_r, diff_nxt;
  logic [DATA_W-1:0] base_r, base_nxt;
  logic [DATA_W-1:0] pow_r, pow_nxt;
  logic [DATA_W-1:0] exp_r, exp_nxt;
  logic [BIT_W-1:0]  k_r, k_nxt;
  logic              pw_inv_r, pw_inv_nxt;
  logic [DATA_W-1:0] ninv_r, ninv_nxt;
  logic              ov_r, ov_nxt;
  logic [DATA_W-1:0] oval_r, oval_nxt;
  logic              olast_r, olast_nxt;
  logic [DATA_W-1:0] q_ld_r, q_ld_nxt;
  logic              redc_r, redc_nxt;
  logic              pre_r, pre_nxt;

  logic [CNT_W-1:0]  n7, half7, len7, a7, b7, cnt1, st_next;
  logic [ADDR_W-1:0] n_m1, rev;
  logic [DATA_W-1:0] qm1, e_stage, exp_stage;
  logic [DATA_W:0]   sum, dif;
  logic              redc_now;

  ntt_r2_mulmod u_mulmod (
    .clk  (clk),
    .rst_n(rst_n),
    .q    (cfg.q),
    .req  (mm_req),
    .rsp  (mm_rsp)
  );

  always_comb begin
    n7        = CNT_W'(1) << cfg.lg;
    n_m1      = ADDR_W'(n7 - CNT_W'(1));
    half7     = CNT_W'(1) << (s_r - LOG_W'(1));
    len7      = CNT_W'(1) << s_r;
    a7        = st_r + CNT_W'(j_r);
    b7        = a7 + half7;
    cnt1      = cnt_r + CNT_W'(1);
    st_next   = st_r + len7;
    rev       = bit_rev(idx_r, cfg.lg);
    qm1       = cfg.q - ONE;
    e_stage   = qm1 >> s_r;
    exp_stage = dir_r ? (qm1 - e_stage) : e_stage;
    redc_now  = (cnt_r != '0) && (redc_r || (cfg.q != q_ld_r));
    sum       = (DATA_W+1)'(u_r) + (DATA_W+1)'(mm_rsp.res);
    if (sum >= (DATA_W+1)'(cfg.q)) begin
      sum = sum - (DATA_W+1)'(cfg.q);
    end
    if (u_r >= mm_rsp.res) begin
      dif = (DATA_W+1)'(u_r) - (DATA_W+1)'(mm_rsp.res);
    end else begin
      dif = (DATA_W+1)'(u_r) + (DATA_W+1)'(cfg.q) - (DATA_W+1)'(mm_rsp.res);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    dir_nxt    = dir_r;
    idx_nxt    = idx_r;
    tmp_nxt    = tmp_r;
    s_nxt      = s_r;
    st_nxt     = st_r;
    j_nxt      = j_r;
    w_nxt      = w_r;
    wl_nxt     = wl_r;
    u_nxt      = u_r;
    diff_nxt   = diff_r;
    base_nxt   = base_r;
    pow_nxt    = pow_r;
    exp_nxt    = exp_r;
    k_nxt      = k_r;
    pw_inv_nxt = pw_inv_r;
    ninv_nxt   = ninv_r;
    ov_nxt     = ov_r;
    oval_nxt   = oval_r;
    olast_nxt  = olast_r;
    q_ld_nxt   = q_ld_r;
    redc_nxt   = redc_r;
    pre_nxt    = pre_r;
    rd_addr    = idx_r;
    wr_en      = 1'b0;
    wr_addr    = idx_r;
    wr_data    = mm_rsp.res;
    mm_req     = '0;
    in_ready   = 1'b0;

    unique case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (cnt_r == '0) begin
            dir_nxt = in_inv;
          end
          mm_req.start = 1'b1;
          mm_req.a     = ONE;
          mm_req.b     = in_coef;
          state_nxt    = S_LRED;
        end
      end
      S_LRED: begin
        if (mm_rsp.done) begin
          wr_en   = 1'b1;
          wr_addr = cnt_r[ADDR_W-1:0];
          if (cnt_r == '0) begin
            q_ld_nxt = cfg.q;
          end
          redc_nxt = redc_now;
          if (cnt1 >= n7) begin
            cnt_nxt = '0;
            idx_nxt = '0;
            pre_nxt = redc_now;
            if (redc_now) begin
              ninv_nxt  = ONE;
              state_nxt = S_SC_RD;
            end else begin
              state_nxt = S_PERM;
            end
          end else begin
            cnt_nxt   = cnt1;
            state_nxt = S_LOAD;
          end
        end
      end
      S_PERM: begin
        if (idx_r < rev) begin
          state_nxt = S_P1;
        end else if (idx_r == n_m1) begin
          s_nxt     = LOG_W'(1);
          state_nxt = S_TW;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_P1: begin
        tmp_nxt   = rdata_r;
        rd_addr   = rev;
        state_nxt = S_P2;
      end
      S_P2: begin
        wr_en     = 1'b1;
        wr_data   = rdata_r;
        state_nxt = S_P3;
      end
      S_P3: begin
        wr_en     = 1'b1;
        wr_addr   = rev;
        wr_data   = tmp_r;
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_PERM;
      end
      S_TW: begin
        mm_req.start = 1'b1;
        mm_req.a     = ONE;
        mm_req.b     = cfg.root;
        state_nxt    = S_TW_W;
      end
      S_TW_W: begin
        if (mm_rsp.done) begin
          base_nxt   = mm_rsp.res;
          exp_nxt    = exp_stage;
          pow_nxt    = ONE;
          k_nxt      = BIT_W'(DATA_W - 1);
          pw_inv_nxt = 1'b0;
          state_nxt  = S_PW_SQ;
        end
      end
      S_PW_SQ: begin
        mm_req.start = 1'b1;
        mm_req.a     = pow_r;
        mm_req.b     = pow_r;
        state_nxt    = S_PW_SQW;
      end
      S_PW_SQW: begin
        if (mm_rsp.done) begin
          pow_nxt   = mm_rsp.res;
          state_nxt = exp_r[k_r] ? S_PW_ML : S_PW_NX;
        end
      end
      S_PW_ML: begin
        mm_req.start = 1'b1;
        mm_req.a     = pow_r;
        mm_req.b     = base_r;
        state_nxt    = S_PW_MLW;
      end
      S_PW_MLW: begin
        if (mm_rsp.done) begin
          pow_nxt   = mm_rsp.res;
          state_nxt = S_PW_NX;
        end
      end
      S_PW_NX: begin
        if (k_r != '0) begin
          k_nxt     = k_r - 1'b1;
          state_nxt = S_PW_SQ;
        end else if (pw_inv_r) begin
          ninv_nxt  = pow_r;
          idx_nxt   = '0;
          state_nxt = S_SC_RD;
        end else begin
          wl_nxt    = pow_r;
          state_nxt = S_BF_INI;
        end
      end
      S_BF_INI: begin
        w_nxt     = ONE;
        st_nxt    = '0;
        j_nxt     = '0;
        state_nxt = S_BF_RA;
      end
      S_BF_RA: begin
        rd_addr   = b7[ADDR_W-1:0];
        state_nxt = S_BF_RB;
      end
      S_BF_RB: begin
        rd_addr      = a7[ADDR_W-1:0];
        mm_req.start = 1'b1;
        mm_req.a     = rdata_r;
        mm_req.b     = w_r;
        state_nxt    = S_BF_U;
      end
      S_BF_U: begin
        u_nxt     = rdata_r;
        state_nxt = S_BF_MW;
      end
      S_BF_MW: begin
        if (mm_rsp.done) begin
          wr_en     = 1'b1;
          wr_addr   = a7[ADDR_W-1:0];
          wr_data   = DATA_W'(sum);
          diff_nxt  = DATA_W'(dif);
          state_nxt = S_BF_WB;
        end
      end
      S_BF_WB: begin
        wr_en        = 1'b1;
        wr_addr      = b7[ADDR_W-1:0];
        wr_data      = diff_r;
        mm_req.start = 1'b1;
        mm_req.a     = w_r;
        mm_req.b     = wl_r;
        state_nxt    = S_BF_WW;
      end
      S_BF_WW: begin
        if (mm_rsp.done) begin
          if (CNT_W'(j_r) == half7 - CNT_W'(1)) begin
            j_nxt  = '0;
            w_nxt  = ONE;
            st_nxt = st_next;
            if (st_next >= n7) begin
              if (s_r == cfg.lg) begin
                if (dir_r) begin
                  state_nxt = S_NV;
                end else begin
                  idx_nxt   = '0;
                  state_nxt = S_OUT_RD;
                end
              end else begin
                s_nxt     = s_r + 1'b1;
                state_nxt = S_TW;
              end
            end else begin
              state_nxt = S_BF_RA;
            end
          end else begin
            j_nxt     = j_r + 1'b1;
            w_nxt     = mm_rsp.res;
            state_nxt = S_BF_RA;
          end
        end
      end
      S_NV: begin
        mm_req.start = 1'b1;
        mm_req.a     = ONE;
        mm_req.b     = DATA_W'(n7);
        state_nxt    = S_NV_W;
      end
      S_NV_W: begin
        if (mm_rsp.done) begin
          base_nxt   = mm_rsp.res;
          exp_nxt    = cfg.q - DATA_W'(2);
          pow_nxt    = ONE;
          k_nxt      = BIT_W'(DATA_W - 1);
          pw_inv_nxt = 1'b1;
          state_nxt  = S_PW_SQ;
        end
      end
      S_SC_RD: begin
        state_nxt = S_SC_M;
      end
      S_SC_M: begin
        mm_req.start = 1'b1;
        mm_req.a     = ninv_r;
        mm_req.b     = rdata_r;
        state_nxt    = S_SC_W;
      end
      S_SC_W: begin
        if (mm_rsp.done) begin
          wr_en = 1'b1;
          if (idx_r == n_m1) begin
            idx_nxt = '0;
            if (pre_r) begin
              pre_nxt   = 1'b0;
              state_nxt = S_PERM;
            end else begin
              state_nxt = S_OUT_RD;
            end
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_SC_RD;
          end
        end
      end
      S_OUT_RD: begin
        state_nxt = S_OUT_LD;
      end
      S_OUT_LD: begin
        oval_nxt  = rdata_r;
        olast_nxt = (idx_r == n_m1);
        ov_nxt    = 1'b1;
        state_nxt = S_OUT_W;
      end
      S_OUT_W: begin
        if (out_ready) begin
          ov_nxt = 1'b0;
          if (olast_r) begin
            state_nxt = S_LOAD;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      dir_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      dir_r   <= dir_nxt;
      ov_r    <= ov_nxt;
    end
    idx_r    <= idx_nxt;
    tmp_r    <= tmp_nxt;
    s_r      <= s_nxt;
    st_r     <= st_nxt;
    j_r      <= j_nxt;
    w_r      <= w_nxt;
    wl_r     <= wl_nxt;
    u_r      <= u_nxt;
    diff_r   <= diff_nxt;
    base_r   <= base_nxt;
    pow_r    <= pow_nxt;
    exp_r    <= exp_nxt;
    k_r      <= k_nxt;
    pw_inv_r <= pw_inv_nxt;
    ninv_r   <= ninv_nxt;
    oval_r   <= oval_nxt;
    olast_r  <= olast_nxt;
    q_ld_r   <= q_ld_nxt;
    redc_r   <= redc_nxt;
    pre_r    <= pre_nxt;
  end

  assign out_valid = ov_r;
  assign out_value = oval_r;
  assign out_last  = olast_r;

endmodule
`default_nettype wire
